// ===== design/ibm_pkg.sv =====
package ibm_pkg;

    localparam int DIRECT_SLOTS_DEF = 7;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int ZONE_W    = 32;
    localparam int ADDR_W    = 56;
    localparam int INNER_W   = 14;
    localparam int BIZ_W     = 7;
    localparam int ZS_W      = 3;
    localparam int BS_W      = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [BS_W-1:0] BS_MIN = 5'd10;
    localparam logic [BS_W-1:0] BS_MAX = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BS_SHIFT   = 1'd1;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REPLY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DATA   = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [ZONE_W-1:0] zone_value;
        logic [ZONE_W-1:0] logical_block;
        logic [ZONE_W-1:0] pointer_word;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic [INNER_W-1:0] inner_idx;
        logic [BIZ_W-1:0]   biz;
    } t_walk_state;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_address;
        logic [ZONE_W-1:0] disk_block;
        logic              is_hole;
    } t_result;

endpackage

// ===== design/ibm_in_if.sv =====
interface ibm_in_if import ibm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ZONE_W-1:0] zone_value;
    logic [ZONE_W-1:0] logical_block;
    logic [ZONE_W-1:0] pointer_word;

    modport source (
        output valid, cmd, slot, zone_value, logical_block, pointer_word,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, zone_value, logical_block, pointer_word,
        output ready
    );
endinterface

// ===== design/ibm_out_if.sv =====
interface ibm_out_if import ibm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] read_address;
    logic [ZONE_W-1:0] disk_block;
    logic              is_hole;

    modport source (
        output valid, kind, read_address, disk_block, is_hole,
        input  ready
    );
    modport sink (
        input  valid, kind, read_address, disk_block, is_hole,
        output ready
    );
endinterface

// ===== design/ibm_zone_store.sv =====
module ibm_zone_store import ibm_pkg::*; #(
    parameter int DIRECT_SLOTS = DIRECT_SLOTS_DEF,
    localparam int IDX_W = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [ZONE_W-1:0] i_value,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [ZONE_W-1:0] o_dir_zone,
    output logic [ZONE_W-1:0] o_single_zone,
    output logic [ZONE_W-1:0] o_double_zone
);

    logic [ZONE_W-1:0] r_dir [DIRECT_SLOTS];
    logic [ZONE_W-1:0] r_single;
    logic [ZONE_W-1:0] r_double;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIRECT_SLOTS; k++) begin
                r_dir[k] <= '0;
            end
            r_single <= '0;
            r_double <= '0;
        end else if (i_we) begin
            if (6'(i_slot) < 6'(DIRECT_SLOTS)) begin
                r_dir[i_slot[IDX_W-1:0]] <= i_value;
            end else if (6'(i_slot) == 6'(DIRECT_SLOTS)) begin
                r_single <= i_value;
            end else if (6'(i_slot) == 6'(DIRECT_SLOTS + 1)) begin
                r_double <= i_value;
            end
        end
    end

    assign o_dir_zone    = (32'(i_rd_idx) < 32'(DIRECT_SLOTS)) ? r_dir[i_rd_idx] : '0;
    assign o_single_zone = r_single;
    assign o_double_zone = r_double;

endmodule

// ===== design/ibm_walk_step.sv =====
module ibm_walk_step import ibm_pkg::*; #(
    parameter int DIRECT_SLOTS = DIRECT_SLOTS_DEF,
    localparam int IDX_W = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1
) (
    input  t_item             i_item,
    input  t_walk_state       i_state,
    input  logic [ZS_W-1:0]   i_zone_shift,
    input  logic [BS_W-1:0]   i_bs_shift,
    input  logic [ZONE_W-1:0] i_dir_zone,
    input  logic [ZONE_W-1:0] i_single_zone,
    input  logic [ZONE_W-1:0] i_double_zone,
    output logic [IDX_W-1:0]  o_dir_idx,
    output logic              o_emit,
    output t_result           o_res,
    output t_walk_state       o_state
);

    function automatic logic [ADDR_W-1:0] word_addr(input logic [ZONE_W-1:0] zone,
                                                    input logic [BS_W-1:0] sh,
                                                    input logic [INNER_W-1:0] idx);
        word_addr = (ADDR_W'(zone) << sh) + ADDR_W'({idx, 2'b00});
    endfunction

    logic [BS_W-1:0]    ebs;
    logic [3:0]         ps;
    logic [INNER_W:0]   ppb;
    logic [INNER_W-1:0] idx_mask;
    logic [BS_W-1:0]    addr_sh;
    logic [ZONE_W-1:0]  lz;
    logic [BIZ_W-1:0]   new_biz;
    logic [ZONE_W-1:0]  rel;
    logic [ZONE_W-1:0]  rel2;
    logic [ZONE_W-1:0]  first;

    logic               do_ans;
    logic [ZONE_W-1:0]  ans_zone;
    logic [BIZ_W-1:0]   ans_biz;

    always_comb begin
        ebs      = (i_bs_shift < BS_MIN) ? BS_MIN : ((i_bs_shift > BS_MAX) ? BS_MAX : i_bs_shift);
        ps       = 4'(ebs - 5'd2);
        ppb      = (INNER_W+1)'(1) << ps;
        idx_mask = INNER_W'(ppb - (INNER_W+1)'(1));
        addr_sh  = ebs + BS_W'(i_zone_shift);
        lz       = i_item.logical_block >> i_zone_shift;
        new_biz  = BIZ_W'(i_item.logical_block) & BIZ_W'((8'd1 << i_zone_shift) - 8'd1);
        rel      = lz - ZONE_W'(DIRECT_SLOTS);
        rel2     = rel - ZONE_W'(ppb);
        first    = rel2 >> ps;
    end

    assign o_dir_idx = lz[IDX_W-1:0];

    always_comb begin
        o_emit   = 1'b0;
        o_state  = i_state;
        o_res    = '0;
        do_ans   = 1'b0;
        ans_zone = '0;
        ans_biz  = i_state.biz;

        case (t_cmd'(i_item.cmd))
            CMD_LOAD: begin
            end
            CMD_LOOKUP: begin
                if (i_state.phase == PH_IDLE) begin
                    o_emit      = 1'b1;
                    o_state.biz = new_biz;
                    ans_biz     = new_biz;
                    if (lz < ZONE_W'(DIRECT_SLOTS)) begin
                        do_ans   = 1'b1;
                        ans_zone = i_dir_zone;
                    end else if (rel < ZONE_W'(ppb)) begin
                        if (i_single_zone == '0) begin
                            do_ans = 1'b1;
                        end else begin
                            o_state.phase      = PH_DATA;
                            o_res.kind         = KIND_READ;
                            o_res.read_address = word_addr(i_single_zone, addr_sh,
                                                           INNER_W'(rel));
                        end
                    end else if (first >= ZONE_W'(ppb) || i_double_zone == '0) begin
                        do_ans = 1'b1;
                    end else begin
                        o_state.inner_idx  = INNER_W'(rel2) & idx_mask;
                        o_state.phase      = PH_SECOND;
                        o_res.kind         = KIND_READ;
                        o_res.read_address = word_addr(i_double_zone, addr_sh,
                                                       INNER_W'(first));
                    end
                end
            end
            CMD_REPLY: begin
                case (i_state.phase)
                    PH_DATA: begin
                        o_emit        = 1'b1;
                        o_state.phase = PH_IDLE;
                        do_ans        = 1'b1;
                        ans_zone      = i_item.pointer_word;
                    end
                    PH_SECOND: begin
                        o_emit = 1'b1;
                        if (i_item.pointer_word == '0) begin
                            o_state.phase = PH_IDLE;
                            do_ans        = 1'b1;
                        end else begin
                            o_state.phase      = PH_DATA;
                            o_res.kind         = KIND_READ;
                            o_res.read_address = word_addr(i_item.pointer_word, addr_sh,
                                                           i_state.inner_idx & idx_mask);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (do_ans) begin
            o_res.kind         = KIND_ANSWER;
            o_res.read_address = '0;
            if (ans_zone == '0) begin
                o_res.is_hole = 1'b1;
            end else begin
                o_res.disk_block = (ans_zone << i_zone_shift) + ZONE_W'(ans_biz);
            end
        end
    end

endmodule

// ===== design/inode_block_map_translate_core.sv =====
// A beat waits in r_in until it fires; any result is then registered in r_out.
// Throughput: one input beat per cycle when the result side keeps up; loads,
// dropped beats and pointer replies all move at that rate.
// Reset: synchronous, active low; clears zone slots, walk phase and pending index,
// configuration registers (zone_shift 0, block_size_shift 10) and both valid flags.
module inode_block_map_translate_core import ibm_pkg::*; #(
    parameter int DIRECT_SLOTS = DIRECT_SLOTS_DEF,
    localparam int IDX_W = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    ibm_in_if.sink               i_in,
    ibm_out_if.source            o_out
);

    logic            r_in_valid;
    t_item           r_in;
    t_walk_state     r_state;
    logic            r_out_valid;
    t_result         r_out;
    logic [ZS_W-1:0] r_zone_shift;
    logic [BS_W-1:0] r_bs_shift;

    logic              fire;
    logic              step_emit;
    t_result           step_res;
    t_walk_state       step_state;
    logic [IDX_W-1:0]  dir_idx;
    logic [ZONE_W-1:0] dir_zone;
    logic [ZONE_W-1:0] single_zone;
    logic [ZONE_W-1:0] double_zone;

    // the step fires only when the result register is free, so state moves in order
    assign fire       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_shift <= '0;
            r_bs_shift   <= BS_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZONE_SHIFT: r_zone_shift <= ZS_W'(i_cfg_data);
                CFG_BS_SHIFT:   r_bs_shift   <= BS_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.cmd           <= i_in.cmd;
            r_in.slot          <= i_in.slot;
            r_in.zone_value    <= i_in.zone_value;
            r_in.logical_block <= i_in.logical_block;
            r_in.pointer_word  <= i_in.pointer_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= PH_IDLE;
            r_state.inner_idx <= '0;
            r_state.biz       <= '0;
        end else if (fire) begin
            r_state <= step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= step_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_emit) begin
            r_out <= step_res;
        end
    end

    ibm_zone_store #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_we          (fire && (t_cmd'(r_in.cmd) == CMD_LOAD)),
        .i_slot        (r_in.slot),
        .i_value       (r_in.zone_value),
        .i_rd_idx      (dir_idx),
        .o_dir_zone    (dir_zone),
        .o_single_zone (single_zone),
        .o_double_zone (double_zone)
    );

    ibm_walk_step #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_step (
        .i_item        (r_in),
        .i_state       (r_state),
        .i_zone_shift  (r_zone_shift),
        .i_bs_shift    (r_bs_shift),
        .i_dir_zone    (dir_zone),
        .i_single_zone (single_zone),
        .i_double_zone (double_zone),
        .o_dir_idx     (dir_idx),
        .o_emit        (step_emit),
        .o_res         (step_res),
        .o_state       (step_state)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.read_address = r_out.read_address;
    assign o_out.disk_block   = r_out.disk_block;
    assign o_out.is_hole      = r_out.is_hole;

    a_read_opens_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_emit && step_res.kind == KIND_READ |=> r_state.phase != PH_IDLE)
        else $error("read request issued without a pending walk");

    a_answer_closes_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_emit && step_res.kind == KIND_ANSWER |=> r_state.phase == PH_IDLE)
        else $error("walk still pending after a final answer");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("input register changed before its step fired");

    a_answer_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_ANSWER |-> r_out.read_address == '0)
        else $error("final answer carries a read address");

    a_read_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_READ |-> r_out.disk_block == '0 && !r_out.is_hole)
        else $error("read request carries answer fields");

endmodule
